// ===== rtl/afdm_pkg.sv =====
// ----------------------------------------------------------------------------
// afdm_pkg - shared types and constants of the frequency / duty meter
// Operation codes, config register indexes, reset values, result limits,
// the prescaler shift table and the divider control/status words.
// ----------------------------------------------------------------------------
package afdm_pkg;

  localparam int SAMPLE_COUNT_BITS_DEF = 16;

  // config port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 27;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ         = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_PERIOD_LIMIT = 1'b1;

  localparam int CLOCK_HZ_W = 27;
  localparam int LIMIT_W    = 16;
  localparam logic [CLOCK_HZ_W-1:0] CLOCK_HZ_RESET  = 27'd48000000;
  localparam logic [LIMIT_W-1:0]    LOW_LIMIT_RESET = 16'd16000;

  // operation codes
  localparam logic OP_CAPTURE = 1'b0;
  localparam logic OP_CLOSE   = 1'b1;

  // field widths
  localparam int TICK_W  = 16;
  localparam int SUM_W   = 32;
  localparam int FREQ_W  = 34;
  localparam int DUTY_W  = 14;
  localparam int RANGE_W = 3;

  localparam logic [FREQ_W-1:0]  FREQ_MAX   = {FREQ_W{1'b1}};
  localparam logic [DUTY_W-1:0]  DUTY_FULL  = 14'd10000;
  localparam logic [RANGE_W-1:0] RANGE_MAX  = 3'd7;
  localparam logic [RANGE_W-1:0] RANGE_MIN  = 3'd0;
  localparam logic [TICK_W-1:0]  COUNT_OUT_MAX = 16'hFFFF;

  // divider iteration count; wide enough for every numerator width
  localparam int DIV_CNT_W = 8;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] count;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_sts_t;

  // prescaler code -> log2 of divider (1,2,4,8,16,64,256,1024)
  function automatic logic [3:0] range_shift(input logic [RANGE_W-1:0] code);
    logic [3:0] sh;
    case (code)
      3'd0: sh = 4'd0;
      3'd1: sh = 4'd1;
      3'd2: sh = 4'd2;
      3'd3: sh = 4'd3;
      3'd4: sh = 4'd4;
      3'd5: sh = 4'd6;
      3'd6: sh = 4'd8;
      3'd7: sh = 4'd10;
      default: sh = 4'd0;
    endcase
    return sh;
  endfunction

endpackage

// ===== rtl/afdm_div.sv =====
// ----------------------------------------------------------------------------
// afdm_div - bit-serial restoring divider
// One quotient bit per cycle, numerator fed MSB first from a shift register.
// The numerator is left aligned by the caller; count gives the bits to use.
// Quotient bits shifted past the top set a sticky overflow flag.
// ----------------------------------------------------------------------------
module afdm_div #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 48,
  parameter int Q_W   = 34
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  afdm_pkg::div_ctl_t        ctl,
  input  logic [NUM_W-1:0]          num,
  input  logic [DEN_W-1:0]          den,
  output afdm_pkg::div_sts_t        sts,
  output logic [Q_W-1:0]            quot
);

  logic [NUM_W-1:0]               num_r;
  logic [DEN_W-1:0]               den_r;
  logic [DEN_W-1:0]               rem_r;
  logic [Q_W-1:0]                 q_r;
  logic                           ovf_r;
  logic [afdm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                           busy_r;
  logic                           done_r;

  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             take;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_r};
  assign take  = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == afdm_pkg::DIV_CNT_W'(1));
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == afdm_pkg::DIV_CNT_W'(1))) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      cnt_r <= ctl.count;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[Q_W-2:0], take};
      ovf_r <= ovf_r | q_r[Q_W-1];
      cnt_r <= cnt_r - afdm_pkg::DIV_CNT_W'(1);
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.ovf  = ovf_r;
  assign quot     = q_r;

endmodule

// ===== rtl/autorange_frequency_duty_meter.sv =====
// ----------------------------------------------------------------------------
// autorange_frequency_duty_meter - reciprocal frequency and duty meter
// Accumulates period / pulse captures over a window with an autoranging
// prescaler and reports mean period, mean pulse, frequency and duty on close.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall): one word is a capture sample or a
//    window close, picked by in_operation. A capture produces nothing; it
//    updates the window sums and the prescale code.
//  - Result channel (out_valid / out_stall): one word per window close.
//  - A close is worked by bit-serial arithmetic: a shift-add multiplier (one
//    multiplier bit per cycle, up to four products) and a restoring divider
//    (one quotient bit per cycle, up to four quotients of 32, 34+N, 46+N and
//    32 bits, N = SAMPLE_COUNT_BITS). An invalid window (a zero sample count)
//    skips the arithmetic and goes straight to the final state.
//  - in_stall is high while a close is being worked; captures are taken
//    every cycle otherwise, also while a result waits in the output register.
//  - out_stall only holds the output register; the next close waits in its
//    final state until that register is free, then loads it and clears the
//    window.
//  - Config (cfg_we / cfg_index / cfg_data) must be written only while idle; the block does not enforce it.
//  - Reset (rst_n low, synchronous) clears sums, counts, recent captures and
//    the prescale code (divide by one), and restores config reset values.
// ----------------------------------------------------------------------------
module autorange_frequency_duty_meter #(
  parameter int SAMPLE_COUNT_BITS = afdm_pkg::SAMPLE_COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // config port
  input  logic                            cfg_we,
  input  logic [afdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afdm_pkg::CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_operation,
  input  logic [15:0]                     in_period_count,
  input  logic [15:0]                     in_pulse_count,
  input  logic                            in_pulse_valid,
  input  logic                            in_capture_error,
  input  logic                            in_counter_overflow,
  // result words
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_mean_period,
  output logic [15:0]                     out_mean_pulse,
  output logic [33:0]                     out_frequency_centihz,
  output logic [13:0]                     out_duty_centipercent,
  output logic [2:0]                      out_prescale_code,
  output logic [15:0]                     out_periods_counted,
  output logic [15:0]                     out_pulses_counted,
  output logic [15:0]                     out_last_period,
  output logic [15:0]                     out_last_pulse,
  output logic                            out_last_overflow,
  output logic                            out_result_valid
);

  localparam int CNT_W  = SAMPLE_COUNT_BITS;
  localparam int SUM_W  = afdm_pkg::SUM_W;
  localparam int PROD_W = SUM_W + CNT_W;                 // sum * count
  localparam int NUM_W  = PROD_W + afdm_pkg::DUTY_W;     // 10000 * sum * count
  localparam int NF_W   = afdm_pkg::FREQ_W + CNT_W;      // clock*100 * count
  localparam int DEN_W  = SUM_W + ((CNT_W > 10) ? CNT_W : 10);
  localparam int ML_W   = (CNT_W > afdm_pkg::DUTY_W) ? CNT_W : afdm_pkg::DUTY_W;
  localparam int SAT_W  = (CNT_W > 16) ? CNT_W : 16;
  localparam int FREQ_W = afdm_pkg::FREQ_W;
  localparam int DUTY_W = afdm_pkg::DUTY_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_NF,
    S_DIV_F,
    S_MUL_A,
    S_MUL_B,
    S_MUL_NA,
    S_DIV_D,
    S_DIV_MP,
    S_DIV_MQ,
    S_OUT
  } state_t;

  // control and window state
  state_t                           state_r, state_nxt;
  logic [afdm_pkg::CLOCK_HZ_W-1:0]  clock_hz_r, clock_hz_nxt;
  logic [afdm_pkg::LIMIT_W-1:0]     low_limit_r, low_limit_nxt;
  logic [SUM_W-1:0]                 period_sum_r, period_sum_nxt;
  logic [SUM_W-1:0]                 pulse_sum_r, pulse_sum_nxt;
  logic [CNT_W-1:0]                 period_samples_r, period_samples_nxt;
  logic [CNT_W-1:0]                 pulse_samples_r, pulse_samples_nxt;
  logic [afdm_pkg::RANGE_W-1:0]     range_code_r, range_code_nxt;
  logic [15:0]                      recent_period_r, recent_period_nxt;
  logic [15:0]                      recent_pulse_r, recent_pulse_nxt;
  logic                             recent_overflow_r, recent_overflow_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // datapath
  logic [NUM_W-1:0]   p_r, p_nxt;      // product accumulator
  logic [NUM_W-1:0]   mc_r, mc_nxt;    // multiplicand, shifts left
  logic [ML_W-1:0]    ml_r, ml_nxt;    // multiplier, shifts right
  logic [PROD_W-1:0]  a_r, a_nxt;      // pulse_sum * periods
  logic [PROD_W-1:0]  b_r, b_nxt;      // period_sum * pulses
  logic [15:0]        mp_r, mp_nxt;
  logic [15:0]        mq_r, mq_nxt;
  logic [FREQ_W-1:0]  freq_r, freq_nxt;
  logic [DUTY_W-1:0]  duty_r, duty_nxt;

  // output payload
  logic [15:0]        o_mean_period_r, o_mean_period_nxt;
  logic [15:0]        o_mean_pulse_r, o_mean_pulse_nxt;
  logic [FREQ_W-1:0]  o_freq_r, o_freq_nxt;
  logic [DUTY_W-1:0]  o_duty_r, o_duty_nxt;
  logic [2:0]         o_prescale_r, o_prescale_nxt;
  logic [15:0]        o_periods_r, o_periods_nxt;
  logic [15:0]        o_pulses_r, o_pulses_nxt;
  logic [15:0]        o_last_period_r, o_last_period_nxt;
  logic [15:0]        o_last_pulse_r, o_last_pulse_nxt;
  logic               o_last_ovf_r, o_last_ovf_nxt;
  logic               o_result_valid_r, o_result_valid_nxt;

  // divider hookup
  afdm_pkg::div_ctl_t div_ctl;
  afdm_pkg::div_sts_t div_sts;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [FREQ_W-1:0]  div_quot;

  // helpers
  logic               in_take;
  logic               window_ok;
  logic [SUM_W:0]     per_add;
  logic [SUM_W:0]     pul_add;
  logic [FREQ_W-1:0]  clk100;
  logic [DEN_W-1:0]   period_den;
  logic [SAT_W-1:0]   per_cnt_ext;
  logic [SAT_W-1:0]   pul_cnt_ext;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign window_ok = (|period_samples_r) && (|pulse_samples_r);
  assign per_add   = {1'b0, period_sum_r} + (SUM_W+1)'(in_period_count);
  assign pul_add   = {1'b0, pulse_sum_r} + (SUM_W+1)'(in_pulse_count);

  // clock_hz * 100 = (x << 6) + (x << 5) + (x << 2)
  assign clk100 = (FREQ_W'(clock_hz_r) << 6) + (FREQ_W'(clock_hz_r) << 5)
                + (FREQ_W'(clock_hz_r) << 2);

  // period sum scaled by the prescaler divider
  assign period_den = DEN_W'({10'b0, period_sum_r} << afdm_pkg::range_shift(range_code_r));

  assign per_cnt_ext = SAT_W'(period_samples_r);
  assign pul_cnt_ext = SAT_W'(pulse_samples_r);

  afdm_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (FREQ_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .num   (div_num),
    .den   (div_den),
    .sts   (div_sts),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt           = state_r;
    clock_hz_nxt        = clock_hz_r;
    low_limit_nxt       = low_limit_r;
    period_sum_nxt      = period_sum_r;
    pulse_sum_nxt       = pulse_sum_r;
    period_samples_nxt  = period_samples_r;
    pulse_samples_nxt   = pulse_samples_r;
    range_code_nxt      = range_code_r;
    recent_period_nxt   = recent_period_r;
    recent_pulse_nxt    = recent_pulse_r;
    recent_overflow_nxt = recent_overflow_r;
    out_valid_nxt       = out_valid_r;

    p_nxt    = p_r;
    mc_nxt   = mc_r;
    ml_nxt   = ml_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    mp_nxt   = mp_r;
    mq_nxt   = mq_r;
    freq_nxt = freq_r;
    duty_nxt = duty_r;

    o_mean_period_nxt  = o_mean_period_r;
    o_mean_pulse_nxt   = o_mean_pulse_r;
    o_freq_nxt         = o_freq_r;
    o_duty_nxt         = o_duty_r;
    o_prescale_nxt     = o_prescale_r;
    o_periods_nxt      = o_periods_r;
    o_pulses_nxt       = o_pulses_r;
    o_last_period_nxt  = o_last_period_r;
    o_last_pulse_nxt   = o_last_pulse_r;
    o_last_ovf_nxt     = o_last_ovf_r;
    o_result_valid_nxt = o_result_valid_r;

    div_ctl = '0;
    div_num = '0;
    div_den = '0;

    // config writes
    if (cfg_we) begin
      case (cfg_index)
        afdm_pkg::CFG_CLOCK_HZ:         clock_hz_nxt  = cfg_data[afdm_pkg::CLOCK_HZ_W-1:0];
        afdm_pkg::CFG_LOW_PERIOD_LIMIT: low_limit_nxt = cfg_data[afdm_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end

    // output register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // shift-add multiplier step, one multiplier bit per cycle
    if (ml_r != '0) begin
      if (ml_r[0]) begin
        p_nxt = p_r + mc_r;
      end
      mc_nxt = {mc_r[NUM_W-2:0], 1'b0};
      ml_nxt = {1'b0, ml_r[ML_W-1:1]};
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_operation == afdm_pkg::OP_CAPTURE) begin
            recent_period_nxt   = in_period_count;
            recent_overflow_nxt = in_counter_overflow;
            if (in_counter_overflow) begin
              if (range_code_r != afdm_pkg::RANGE_MAX) begin
                range_code_nxt = range_code_r + 3'd1;
              end
            end else if (in_period_count < low_limit_r) begin
              if (range_code_r != afdm_pkg::RANGE_MIN) begin
                range_code_nxt = range_code_r - 3'd1;
              end
            end
            if (in_pulse_valid) begin
              recent_pulse_nxt = in_pulse_count;
              if (!in_capture_error && !(&pulse_samples_r) && !pul_add[SUM_W]) begin
                pulse_samples_nxt = pulse_samples_r + CNT_W'(1);
                pulse_sum_nxt     = pul_add[SUM_W-1:0];
              end
            end
            if (!in_capture_error && !(&period_samples_r) && !per_add[SUM_W]) begin
              period_samples_nxt = period_samples_r + CNT_W'(1);
              period_sum_nxt     = per_add[SUM_W-1:0];
            end
          end else if (window_ok) begin
            p_nxt     = '0;
            mc_nxt    = NUM_W'(clk100);
            ml_nxt    = ML_W'(period_samples_r);
            state_nxt = S_MUL_NF;
          end else begin
            mp_nxt    = '0;
            mq_nxt    = '0;
            freq_nxt  = '0;
            duty_nxt  = '0;
            state_nxt = S_OUT;
          end
        end
      end

      S_MUL_NF: begin
        if (ml_r == '0) begin
          div_ctl.start = 1'b1;
          div_ctl.count = afdm_pkg::DIV_CNT_W'(NF_W);
          div_num       = {p_r[NF_W-1:0], {(NUM_W-NF_W){1'b0}}};
          div_den       = period_den;
          state_nxt     = S_DIV_F;
        end
      end

      S_DIV_F: begin
        if (div_sts.done) begin
          freq_nxt  = div_sts.ovf ? afdm_pkg::FREQ_MAX : div_quot;
          p_nxt     = '0;
          mc_nxt    = NUM_W'(pulse_sum_r);
          ml_nxt    = ML_W'(period_samples_r);
          state_nxt = S_MUL_A;
        end
      end

      S_MUL_A: begin
        if (ml_r == '0) begin
          a_nxt     = p_r[PROD_W-1:0];
          p_nxt     = '0;
          mc_nxt    = NUM_W'(period_sum_r);
          ml_nxt    = ML_W'(pulse_samples_r);
          state_nxt = S_MUL_B;
        end
      end

      S_MUL_B: begin
        if (ml_r == '0) begin
          b_nxt = p_r[PROD_W-1:0];
          if (a_r >= p_r[PROD_W-1:0]) begin
            duty_nxt      = afdm_pkg::DUTY_FULL;
            div_ctl.start = 1'b1;
            div_ctl.count = afdm_pkg::DIV_CNT_W'(SUM_W);
            div_num       = {period_sum_r, {(NUM_W-SUM_W){1'b0}}};
            div_den       = DEN_W'(period_samples_r);
            state_nxt     = S_DIV_MP;
          end else begin
            p_nxt     = '0;
            mc_nxt    = NUM_W'(a_r);
            ml_nxt    = ML_W'(afdm_pkg::DUTY_FULL);
            state_nxt = S_MUL_NA;
          end
        end
      end

      S_MUL_NA: begin
        if (ml_r == '0) begin
          div_ctl.start = 1'b1;
          div_ctl.count = afdm_pkg::DIV_CNT_W'(NUM_W);
          div_num       = p_r;
          div_den       = DEN_W'(b_r);
          state_nxt     = S_DIV_D;
        end
      end

      S_DIV_D: begin
        if (div_sts.done) begin
          duty_nxt      = div_quot[DUTY_W-1:0];
          div_ctl.start = 1'b1;
          div_ctl.count = afdm_pkg::DIV_CNT_W'(SUM_W);
          div_num       = {period_sum_r, {(NUM_W-SUM_W){1'b0}}};
          div_den       = DEN_W'(period_samples_r);
          state_nxt     = S_DIV_MP;
        end
      end

      S_DIV_MP: begin
        if (div_sts.done) begin
          mp_nxt        = div_quot[15:0];
          div_ctl.start = 1'b1;
          div_ctl.count = afdm_pkg::DIV_CNT_W'(SUM_W);
          div_num       = {pulse_sum_r, {(NUM_W-SUM_W){1'b0}}};
          div_den       = DEN_W'(pulse_samples_r);
          state_nxt     = S_DIV_MQ;
        end
      end

      S_DIV_MQ: begin
        if (div_sts.done) begin
          mq_nxt    = div_quot[15:0];
          state_nxt = S_OUT;
        end
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          o_mean_period_nxt = mp_r;
          o_mean_pulse_nxt  = mq_r;
          // zero period sum with live counts: pin frequency and duty
          if (window_ok && (period_sum_r == '0)) begin
            o_freq_nxt = afdm_pkg::FREQ_MAX;
            o_duty_nxt = afdm_pkg::DUTY_FULL;
          end else begin
            o_freq_nxt = freq_r;
            o_duty_nxt = duty_r;
          end
          o_prescale_nxt     = range_code_r;
          o_periods_nxt      = (per_cnt_ext > SAT_W'(afdm_pkg::COUNT_OUT_MAX))
                             ? afdm_pkg::COUNT_OUT_MAX : per_cnt_ext[15:0];
          o_pulses_nxt       = (pul_cnt_ext > SAT_W'(afdm_pkg::COUNT_OUT_MAX))
                             ? afdm_pkg::COUNT_OUT_MAX : pul_cnt_ext[15:0];
          o_last_period_nxt  = recent_period_r;
          o_last_pulse_nxt   = recent_pulse_r;
          o_last_ovf_nxt     = recent_overflow_r;
          o_result_valid_nxt = window_ok;
          out_valid_nxt      = 1'b1;
          // window restarts
          period_sum_nxt     = '0;
          pulse_sum_nxt      = '0;
          period_samples_nxt = '0;
          pulse_samples_nxt  = '0;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      clock_hz_r        <= afdm_pkg::CLOCK_HZ_RESET;
      low_limit_r       <= afdm_pkg::LOW_LIMIT_RESET;
      period_sum_r      <= '0;
      pulse_sum_r       <= '0;
      period_samples_r  <= '0;
      pulse_samples_r   <= '0;
      range_code_r      <= afdm_pkg::RANGE_MIN;
      recent_period_r   <= '0;
      recent_pulse_r    <= '0;
      recent_overflow_r <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      state_r           <= state_nxt;
      clock_hz_r        <= clock_hz_nxt;
      low_limit_r       <= low_limit_nxt;
      period_sum_r      <= period_sum_nxt;
      pulse_sum_r       <= pulse_sum_nxt;
      period_samples_r  <= period_samples_nxt;
      pulse_samples_r   <= pulse_samples_nxt;
      range_code_r      <= range_code_nxt;
      recent_period_r   <= recent_period_nxt;
      recent_pulse_r    <= recent_pulse_nxt;
      recent_overflow_r <= recent_overflow_nxt;
      out_valid_r       <= out_valid_nxt;
    end
  end

  // datapath and result payload, no reset
  always_ff @(posedge clk) begin
    p_r              <= p_nxt;
    mc_r             <= mc_nxt;
    ml_r             <= ml_nxt;
    a_r              <= a_nxt;
    b_r              <= b_nxt;
    mp_r             <= mp_nxt;
    mq_r             <= mq_nxt;
    freq_r           <= freq_nxt;
    duty_r           <= duty_nxt;
    o_mean_period_r  <= o_mean_period_nxt;
    o_mean_pulse_r   <= o_mean_pulse_nxt;
    o_freq_r         <= o_freq_nxt;
    o_duty_r         <= o_duty_nxt;
    o_prescale_r     <= o_prescale_nxt;
    o_periods_r      <= o_periods_nxt;
    o_pulses_r       <= o_pulses_nxt;
    o_last_period_r  <= o_last_period_nxt;
    o_last_pulse_r   <= o_last_pulse_nxt;
    o_last_ovf_r     <= o_last_ovf_nxt;
    o_result_valid_r <= o_result_valid_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_mean_period       = o_mean_period_r;
  assign out_mean_pulse        = o_mean_pulse_r;
  assign out_frequency_centihz = o_freq_r;
  assign out_duty_centipercent = o_duty_r;
  assign out_prescale_code     = o_prescale_r;
  assign out_periods_counted   = o_periods_r;
  assign out_pulses_counted    = o_pulses_r;
  assign out_last_period       = o_last_period_r;
  assign out_last_pulse        = o_last_pulse_r;
  assign out_last_overflow     = o_last_ovf_r;
  assign out_result_valid      = o_result_valid_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_capture_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_operation == afdm_pkg::OP_CAPTURE)) |=> (state_r == S_IDLE))
    else $error("capture left idle state");

  a_duty_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (o_duty_r <= afdm_pkg::DUTY_FULL))
    else $error("duty above full scale");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !o_result_valid_r) |->
      ((o_freq_r == '0) && (o_duty_r == '0) && (o_mean_period_r == '0)
       && (o_mean_pulse_r == '0)))
    else $error("invalid window with nonzero results");

  a_valid_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_result_valid_r) |-> ((o_periods_r != '0) && (o_pulses_r != '0)))
    else $error("valid result with empty count");

endmodule
